[sv/e2e_pkg.sv]
package e2e_pkg;

  localparam logic [7:0] CRC_POLY   = 8'h1D;
  localparam logic [7:0] CRC_SEED   = 8'hFF;
  localparam logic [7:0] NIBBLE_LO  = 8'h0F;
  localparam logic [7:0] NIBBLE_HI  = 8'hF0;
  localparam logic [7:0] CRC_TOPBIT = 8'h80;

  localparam logic REQ_PROTECT = 1'b0;
  localparam logic REQ_CHECK   = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } e2e_cmd_t;

  typedef struct packed {
    logic short_frame;
    logic last_step;
  } e2e_stat_t;

  // One byte of the MSB-first CRC-8: eight shift steps on an 8-bit value.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOPBIT) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/e2e_ctrl.sv]
module e2e_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                res_valid,
  input  logic                res_stall,
  input  e2e_pkg::e2e_stat_t  stat,
  output e2e_pkg::e2e_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_full;
  logic       out_full_next;
  logic       out_free;

  assign out_free  = !out_full || !res_stall;
  assign req_stall = (state != S_IDLE);
  assign res_valid = out_full;

  always_comb begin
    state_next    = state;
    out_full_next = out_full;
    cmd           = '0;
    if (out_full && !res_stall) begin
      out_full_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        // A short frame skips the CRC loop entirely.
        if (stat.short_frame) begin
          state_next = S_FIN;
        end else begin
          cmd.step = 1'b1;
          if (stat.last_step) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_full_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

[sv/e2e_dpath.sv]
module e2e_dpath #(
  parameter int MAX_FRAME_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  e2e_pkg::e2e_cmd_t   cmd,
  output e2e_pkg::e2e_stat_t  stat,
  input  logic                req_type,
  input  logic [63:0]         frame_in,
  input  logic [3:0]          frame_length,
  input  logic [7:0]          data_id,
  output logic [63:0]         frame_out,
  output logic                status,
  output logic [7:0]          crc_out,
  output logic [3:0]          alive_value
);

  localparam int IDX_W = (MAX_FRAME_BYTES > 2) ? $clog2(MAX_FRAME_BYTES) : 1;

  logic [3:0]       tx_alive_counter;
  logic [63:0]      frame_work;
  logic [3:0]       len_work;
  logic [7:0]       crc_work;
  logic [3:0]       alive_work;
  logic             req_work;
  logic             short_work;
  logic [IDX_W-1:0] idx;

  logic [3:0]       len_sat;
  logic             len_short;
  logic [7:0]       byte1_prot;
  logic [7:0]       cur_byte;

  assign len_sat    = (frame_length > 4'(MAX_FRAME_BYTES)) ? 4'(MAX_FRAME_BYTES)
                                                           : frame_length;
  assign len_short  = (len_sat < 4'd2);
  assign byte1_prot = (frame_in[15:8] & e2e_pkg::NIBBLE_HI) | {4'h0, tx_alive_counter};
  assign cur_byte   = frame_work[{idx, 3'b000} +: 8];

  assign stat.short_frame = short_work;
  assign stat.last_step   = ((4'(idx) + 4'd1) == len_work);

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_alive_counter <= 4'd0;
    end else if (cmd.load && !len_short && (req_type == e2e_pkg::REQ_PROTECT)) begin
      tx_alive_counter <= tx_alive_counter + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_work   <= req_type;
      len_work   <= len_sat;
      short_work <= len_short;
      crc_work   <= e2e_pkg::CRC_SEED ^ data_id;
      idx        <= IDX_W'(1);
      if (!len_short && (req_type == e2e_pkg::REQ_PROTECT)) begin
        frame_work <= {frame_in[63:16], byte1_prot, frame_in[7:0]};
        alive_work <= tx_alive_counter;
      end else begin
        frame_work <= frame_in;
        alive_work <= frame_in[11:8];
      end
    end else if (cmd.step) begin
      crc_work <= e2e_pkg::crc8_byte(crc_work, cur_byte);
      idx      <= idx + IDX_W'(1);
    end
  end

  // Result registers, loaded once the output slot is free.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (short_work) begin
        frame_out   <= frame_work;
        status      <= 1'b1;
        crc_out     <= 8'h00;
        alive_value <= 4'h0;
      end else if (req_work == e2e_pkg::REQ_PROTECT) begin
        frame_out   <= {frame_work[63:8], crc_work};
        status      <= 1'b0;
        crc_out     <= crc_work;
        alive_value <= alive_work;
      end else begin
        frame_out   <= frame_work;
        status      <= (frame_work[7:0] != crc_work);
        crc_out     <= crc_work;
        alive_value <= alive_work;
      end
    end
  end

endmodule

[sv/e2e_frame_protect_check_unit.sv]
// End-to-end frame protect and check unit. A request carries a frame of up to
// MAX_FRAME_BYTES bytes, its length, a data ID and a request type. Protect inserts the
// transmit alive counter into the low nibble of byte 1, writes a CRC-8 (poly 0x1D,
// seed 0xFF XOR data ID, no final XOR) over bytes 1 to length-1 into byte 0 and then
// advances the counter; check compares byte 0 against that CRC and reports the
// received alive nibble. A length below 2 returns status 1 with the frame echoed.
// Lengths above MAX_FRAME_BYTES are treated as MAX_FRAME_BYTES. One request is
// handled at a time: the CRC unit folds in one byte per cycle, and the next request
// is accepted the cycle after the result is registered, even while that result still
// waits to be taken.
module e2e_frame_protect_check_unit #(
  parameter int MAX_FRAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [63:0] frame_in,
  input  logic [3:0]  frame_length,
  input  logic [7:0]  data_id,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] frame_out,
  output logic        status,
  output logic [7:0]  crc_out,
  output logic [3:0]  alive_value
);

  e2e_pkg::e2e_cmd_t  cmd;
  e2e_pkg::e2e_stat_t stat;

  e2e_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  e2e_dpath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .frame_in     (frame_in),
    .frame_length (frame_length),
    .data_id      (data_id),
    .frame_out    (frame_out),
    .status       (status),
    .crc_out      (crc_out),
    .alive_value  (alive_value)
  );

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES  = 8;
  localparam int RANDOM_ITEMS = 1330;
  localparam int N_DIRECTED   = 20;

  typedef struct packed {
    logic [63:0] frame;
    logic        status;
    logic [7:0]  crc;
    logic [3:0]  alive;
  } e2e_result_t;

  // One row of stimulus. A typed row carries its own expected result.
  typedef struct packed {
    logic        rtype;
    logic [63:0] frame;
    logic [3:0]  len;
    logic [7:0]  id;
    logic        good_crc;
    logic        typed;
    e2e_result_t want;
  } stim_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_HOLD} sink_mode_t;

  localparam e2e_result_t UNTYPED = '0;
  localparam logic [63:0] ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{e2e_pkg::REQ_PROTECT, 64'h0, 4'd2, 8'hFF, 1'b0, 1'b1, '{64'h0, 1'b0, 8'h00, 4'h0}},
    '{e2e_pkg::REQ_PROTECT, ONES, 4'd0, 8'h00, 1'b0, 1'b1, '{ONES, 1'b1, 8'h00, 4'h0}},
    '{e2e_pkg::REQ_CHECK, ONES, 4'd1, 8'hFF, 1'b0, 1'b1, '{ONES, 1'b1, 8'h00, 4'h0}},
    '{e2e_pkg::REQ_PROTECT, 64'h0123_4567_89AB_CDEF, 4'd1, 8'h3C, 1'b0, 1'b1,
      '{64'h0123_4567_89AB_CDEF, 1'b1, 8'h00, 4'h0}},
    '{e2e_pkg::REQ_CHECK, 64'h0, 4'd2, 8'hFF, 1'b0, 1'b1, '{64'h0, 1'b0, 8'h00, 4'h0}},
    '{e2e_pkg::REQ_CHECK, 64'h1, 4'd2, 8'hFF, 1'b0, 1'b1, '{64'h1, 1'b1, 8'h00, 4'h0}},
    '{e2e_pkg::REQ_CHECK, 64'h0F00, 4'd2, 8'h00, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_PROTECT, ONES, 4'd8, 8'h00, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_PROTECT, ONES, 4'd15, 8'hFF, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_CHECK, ONES, 4'd9, 8'hA5, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_PROTECT, 64'h0, 4'd8, 8'h00, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_CHECK, 64'hFFEE_DDCC_BBAA_9988, 4'd3, 8'h5A, 1'b1, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_PROTECT, 64'hDEAD_BEEF_CAFE_F00D, 4'd4, 8'h80, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_CHECK, 64'hDEAD_BEEF_CAFE_F00D, 4'd7, 8'h80, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_PROTECT, 64'h7766_5544_3322_1100, 4'd2, 8'h01, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_CHECK, 64'h8000_0000_0000_0000, 4'd8, 8'hFF, 1'b1, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_PROTECT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd5, 8'h55, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_CHECK, 64'h5555_5555_5555_5555, 4'd0, 8'hAA, 1'b0, 1'b1,
      '{64'h5555_5555_5555_5555, 1'b1, 8'h00, 4'h0}},
    '{e2e_pkg::REQ_PROTECT, 64'h5555_5555_5555_5555, 4'd6, 8'hAA, 1'b0, 1'b0, UNTYPED},
    '{e2e_pkg::REQ_CHECK, 64'h0123_4567_89AB_CDEF, 4'd12, 8'h3C, 1'b1, 1'b0, UNTYPED}
  };

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        req_valid    = 1'b0;
  logic        req_type     = e2e_pkg::REQ_PROTECT;
  logic [63:0] frame_in     = '0;
  logic [3:0]  frame_length = '0;
  logic [7:0]  data_id      = '0;
  logic        res_stall    = 1'b0;
  logic        req_stall;
  logic        res_valid;
  logic [63:0] frame_out;
  logic        status;
  logic [7:0]  crc_out;
  logic [3:0]  alive_value;

  // Typed expectation that travels alongside the request on the wire.
  logic        row_typed = 1'b0;
  e2e_result_t row_want  = '0;

  logic [3:0]  tx_alive = 4'h0;
  e2e_result_t pending_results [$];
  int unsigned mismatches = 0;

  always #1 clk = ~clk;

  e2e_frame_protect_check_unit #(
    .MAX_FRAME_BYTES(FRAME_BYTES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .frame_in(frame_in),
    .frame_length(frame_length),
    .data_id(data_id),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .frame_out(frame_out),
    .status(status),
    .crc_out(crc_out),
    .alive_value(alive_value)
  );

  // CRC-8 over bytes 1 .. len-1; lengths past the frame size are clipped.
  function automatic logic [7:0] e2e_crc(input logic [63:0] frame, input logic [3:0] len,
                                         input logic [7:0] id);
    logic [7:0]  acc;
    int unsigned n;
    acc = e2e_pkg::CRC_SEED ^ id;
    n = (len > FRAME_BYTES) ? FRAME_BYTES : len;
    for (int i = 1; i < n; i++) begin
      acc = acc ^ frame[8*i +: 8];
      for (int b = 0; b < 8; b++) begin
        acc = acc[7] ? ({acc[6:0], 1'b0} ^ e2e_pkg::CRC_POLY) : {acc[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

  function automatic e2e_result_t frame_result(input logic rtype, input logic [63:0] frame,
                                               input logic [3:0] len, input logic [7:0] id);
    e2e_result_t r;
    r = '{frame: frame, status: 1'b0, crc: 8'h00, alive: 4'h0};
    if (len < 4'd2) begin
      r.status = 1'b1;
    end else if (rtype == e2e_pkg::REQ_PROTECT) begin
      r.alive = tx_alive;
      r.frame[11:8] = tx_alive;
      r.crc = e2e_crc(r.frame, len, id);
      r.frame[7:0] = r.crc;
      tx_alive = tx_alive + 4'd1;
    end else begin
      r.crc = e2e_crc(frame, len, id);
      r.alive = frame[11:8];
      r.status = (frame[7:0] != r.crc);
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  // Presents one transaction, after an optional idle gap, and returns at the
  // clock edge where it is taken.
  task automatic offer(input stim_row_t r, input logic no_gap);
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (no_gap || roll < 55) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (r.good_crc) begin
      r.frame[7:0] = e2e_crc(r.frame, r.len, r.id);
    end
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    req_type     <= r.rtype;
    frame_in     <= r.frame;
    frame_length <= r.len;
    data_id      <= r.id;
    row_typed    <= r.typed;
    row_want     <= r.want;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    e2e_result_t want;
    e2e_result_t got;
    string       diff;
    if (!rst && req_valid && !req_stall) begin
      want = frame_result(req_type, frame_in, frame_length, data_id);
      if (row_typed) begin
        want = row_want;
      end
      pending_results.push_back(want);
    end
    if (!rst && res_valid && !res_stall) begin
      got = '{frame: frame_out, status: status, crc: crc_out, alive: alive_value};
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result frame %h", got.frame));
      end else begin
        want = pending_results.pop_front();
        diff = "";
        if (got.frame !== want.frame) begin
          diff = {diff, $sformatf(" frame %h want %h", got.frame, want.frame)};
        end
        if (got.status !== want.status) begin
          diff = {diff, $sformatf(" status %b want %b", got.status, want.status)};
        end
        if (got.crc !== want.crc) begin
          diff = {diff, $sformatf(" crc %h want %h", got.crc, want.crc)};
        end
        if (got.alive !== want.alive) begin
          diff = {diff, $sformatf(" alive %h want %h", got.alive, want.alive)};
        end
        if (diff != "") begin
          flag_mismatch({"result differs:", diff});
        end
      end
    end
  end

  // Receiver pacing. One long hold-off is forced early so that the unit
  // fills up and pushes back on the sender.
  initial begin : sink_pacing
    sink_mode_t  mode;
    int unsigned left;
    int unsigned cyc;
    int unsigned roll;
    mode = SINK_OPEN;
    left = 0;
    cyc  = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 400) begin
        mode = SINK_HOLD;
        left = 150;
      end else if (left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          mode = SINK_OPEN;
          left = $urandom_range(10, 60);
        end else if (roll < 97) begin
          mode = SINK_CHOPPY;
          left = $urandom_range(10, 60);
        end else begin
          mode = SINK_HOLD;
          left = $urandom_range(40, 120);
        end
      end
      left--;
      case (mode)
        SINK_OPEN: begin
          res_stall <= 1'b0;
        end
        SINK_CHOPPY: begin
          res_stall <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          res_stall <= 1'b1;
        end
      endcase
    end
  end

  initial begin : source
    stim_row_t   row;
    int unsigned pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(DIRECTED_ROWS[i], 1'b0);
    end
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      row = '0;
      row.rtype = 1'($urandom_range(0, 1));
      row.frame = {$urandom, $urandom};
      row.id = 8'($urandom_range(0, 255));
      if (pick < 6) begin
        row.len = 4'($urandom_range(0, 1));
      end else if (pick < 14) begin
        row.len = 4'($urandom_range(9, 15));
      end else begin
        row.len = 4'($urandom_range(2, 8));
      end
      // Most checks carry a correct CRC so the match path is exercised.
      row.good_crc = (row.rtype == e2e_pkg::REQ_CHECK) && ($urandom_range(0, 9) < 7);
      offer(row, ((k / 50) % 3) == 0);
    end
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("e2e_frame_protect_check_unit: match");
    end else begin
      $display("e2e_frame_protect_check_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("e2e_frame_protect_check_unit: mismatch");
    $finish;
  end

endmodule

[filelist.f]
sv/e2e_pkg.sv
sv/e2e_ctrl.sv
sv/e2e_dpath.sv
sv/e2e_frame_protect_check_unit.sv
verif/tb.sv
